### design/irds_pkg.sv
package irds_pkg;

    localparam int MAX_DST_WIDTH = 1024;
    localparam int MAX_SRC_DIM   = 4096;
    localparam int MAX_CHANNELS  = 4;

    localparam int COL_W    = $clog2(MAX_DST_WIDTH);
    localparam int SRC_W    = $clog2(MAX_SRC_DIM);
    localparam int COL_ACC_W = 23;
    localparam int ROW_ACC_W = 25;
    localparam int SUM_W    = 32;
    localparam int CNT_W    = 25;
    localparam int LUMA_W   = 9;
    localparam int DIV_STEPS = 32;

    localparam logic [14:0] LUMA_K_R = 15'd6969;
    localparam logic [14:0] LUMA_K_G = 15'd23434;
    localparam logic [14:0] LUMA_K_B = 15'd2365;

    localparam logic [1:0] MODE_AVG = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;
    localparam logic [1:0] MODE_MIN = 2'd2;

    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] REG_MODE       = 3'd4;
    localparam logic [2:0] REG_CHANNELS   = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [SUM_W-1:0]  sum_alpha;
        logic [SUM_W-1:0]  sum_blue;
        logic [SUM_W-1:0]  sum_green;
        logic [SUM_W-1:0]  sum_red;
        logic [LUMA_W-1:0] best_luma;
        logic [31:0]       best_pixel;
        logic [CNT_W-1:0]  pixel_count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

### design/irds_ram.sv
module irds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/image_region_downscaler_unit.sv
// Region box-filter downscaler.
// Source pixels enter on the s_axis channel in raster order, one beat per pixel
// (red in tdata bits 7:0 up to alpha in bits 31:24). The source is cut into a grid
// of dst_width by dst_height regions and, when the last pixel of a region arrives,
// one reduced pixel leaves on m_axis together with its destination row and column.
// Results therefore come in destination raster order.
// Per-column accumulators live in one 1024-entry synchronous RAM. Each beat takes a
// read step (ST_IDLE) and a modify/write-back step (ST_MOD); a pixel that closes no
// region goes back to ST_IDLE. A region closed in average mode runs a radix-2
// restoring divider (ST_DIV) before ST_OUT loads the output register. Max, min and
// unused modes go from ST_MOD straight to ST_OUT.
// The result sits in an output register: the block takes the next pixel while the
// previous result is still waiting. If the receiver stalls and another region closes,
// the block holds in its output state until the register frees up.
// Reset and any write to a configuration register restart the frame: positions go to
// zero, and the first pixel of each region starts its accumulator from zero, so no
// clearing pass over the RAM is needed. The block is not ready while r_init, which
// reset or a write sets, is high. Region boundaries are tracked by adding the sizes, without any divide.
module image_region_downscaler_unit
    import irds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // out_red, out_green, out_blue, out_alpha,
                                        // out_row, out_col, 2 zero bits
);

    // Configuration registers.
    logic [12:0] r_src_width, r_src_height, r_dst_height;
    logic [10:0] r_dst_width;
    logic [1:0]  r_mode;
    logic [2:0]  r_channels;
    logic        r_init;
    logic        cfg_hit;

    // Effective (clamped) sizes.
    logic [12:0] sw_e, sh_e, dh_e;
    logic [10:0] dw_e, dw_hi;

    // Position tracking.
    logic [SRC_W-1:0]     r_src_col, r_src_row, r_dst_row;
    logic [COL_W-1:0]     r_dst_col;
    logic [COL_ACC_W-1:0] r_col_a, r_col_b;
    logic [ROW_ACC_W-1:0] r_row_a, r_row_b;
    logic                 r_col_first, r_row_first;

    // Item in flight.
    t_state           r_state, n_state;
    logic [7:0]       r_px_r, r_px_g, r_px_b, r_px_a;
    logic [COL_W-1:0] r_item_col;
    logic [SRC_W-1:0] r_item_row;
    logic             r_item_fresh;
    logic             r_item_emit;

    // RAM.
    logic             ram_we;
    logic [COL_W-1:0] ram_addr;
    t_entry           ram_wdata, ram_rdata;

    // Modify stage.
    t_entry      old_e, n_entry;
    logic [23:0] luma_sum;
    logic [LUMA_W-1:0] luma;
    logic [31:0] pix;
    logic        last_col, last_row, accept;

    // Divider.
    logic [SUM_W-1:0] r_dvd [4];
    logic [CNT_W:0]   r_rem [4];
    logic [CNT_W-1:0] r_divisor;
    logic [4:0]       r_div_cnt;
    logic [31:0]      r_res_pix;
    logic [CNT_W:0]   trial [4];
    logic [CNT_W:0]   rem_sh [4];

    // Output register.
    logic        r_m_valid;
    logic [55:0] r_m_data;
    logic [31:0] out_pix;
    logic        out_load;

    assign cfg_hit = i_cfg_we && (i_cfg_idx == REG_SRC_WIDTH || i_cfg_idx == REG_SRC_HEIGHT
                     || i_cfg_idx == REG_DST_WIDTH || i_cfg_idx == REG_DST_HEIGHT
                     || i_cfg_idx == REG_MODE || i_cfg_idx == REG_CHANNELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= 13'd1;
            r_src_height <= 13'd1;
            r_dst_width  <= 11'd1;
            r_dst_height <= 13'd1;
            r_mode       <= MODE_AVG;
            r_channels   <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                REG_DST_WIDTH:  r_dst_width  <= i_cfg_data[10:0];
                REG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                REG_MODE:       r_mode       <= i_cfg_data[1:0];
                REG_CHANNELS:   r_channels   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Sizes are clamped so that only downscaling ever happens.
    always_comb begin
        sw_e = (r_src_width == 13'd0) ? 13'd1
             : (r_src_width > 13'(MAX_SRC_DIM)) ? 13'(MAX_SRC_DIM) : r_src_width;
        sh_e = (r_src_height == 13'd0) ? 13'd1
             : (r_src_height > 13'(MAX_SRC_DIM)) ? 13'(MAX_SRC_DIM) : r_src_height;
        dw_hi = (sw_e < 13'(MAX_DST_WIDTH)) ? sw_e[10:0] : 11'(MAX_DST_WIDTH);
        dw_e = (r_dst_width == 11'd0) ? 11'd1
             : (r_dst_width > dw_hi) ? dw_hi : r_dst_width;
        dh_e = (r_dst_height == 13'd0) ? 13'd1
             : (r_dst_height > sh_e) ? sh_e : r_dst_height;
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !r_init;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // A column region closes when (src_col+2)*dw exceeds (dst_col+1)*sw; rows alike.
    assign last_col = ({1'b0, r_col_a} + 24'(dw_e)) > {1'b0, r_col_b};
    assign last_row = ({1'b0, r_row_a} + 26'(dh_e)) > {1'b0, r_row_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b1;
        end else begin
            r_init <= cfg_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_dst_col   <= '0;
            r_dst_row   <= '0;
            r_col_first <= 1'b1;
            r_row_first <= 1'b1;
        end else if (r_init) begin
            r_col_a <= COL_ACC_W'(dw_e);
            r_col_b <= COL_ACC_W'(sw_e);
            r_row_a <= ROW_ACC_W'(dh_e);
            r_row_b <= ROW_ACC_W'(sh_e);
        end else if (accept) begin
            if ({1'b0, r_src_col} + 13'd1 == sw_e) begin
                r_src_col   <= '0;
                r_dst_col   <= '0;
                r_col_a     <= COL_ACC_W'(dw_e);
                r_col_b     <= COL_ACC_W'(sw_e);
                r_col_first <= 1'b1;
                if ({1'b0, r_src_row} + 13'd1 == sh_e) begin
                    r_src_row   <= '0;
                    r_dst_row   <= '0;
                    r_row_a     <= ROW_ACC_W'(dh_e);
                    r_row_b     <= ROW_ACC_W'(sh_e);
                    r_row_first <= 1'b1;
                end else begin
                    r_src_row <= r_src_row + 1'b1;
                    r_row_a   <= r_row_a + ROW_ACC_W'(dh_e);
                    if (last_row) begin
                        r_dst_row   <= r_dst_row + 1'b1;
                        r_row_b     <= r_row_b + ROW_ACC_W'(sh_e);
                        r_row_first <= 1'b1;
                    end else begin
                        r_row_first <= 1'b0;
                    end
                end
            end else begin
                r_src_col <= r_src_col + 1'b1;
                r_col_a   <= r_col_a + COL_ACC_W'(dw_e);
                if (last_col) begin
                    r_dst_col   <= r_dst_col + 1'b1;
                    r_col_b     <= r_col_b + COL_ACC_W'(sw_e);
                    r_col_first <= 1'b1;
                end else begin
                    r_col_first <= 1'b0;
                end
            end
        end
    end

    // Capture the beat; the RAM is read at the same edge.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px_r       <= s_axis_tdata[7:0];
            r_px_g       <= s_axis_tdata[15:8];
            r_px_b       <= s_axis_tdata[23:16];
            r_px_a       <= (r_channels == 3'd4) ? s_axis_tdata[31:24] : 8'd0;
            r_item_col   <= r_dst_col;
            r_item_row   <= r_dst_row;
            r_item_fresh <= r_col_first && r_row_first;
            r_item_emit  <= last_col && last_row;
        end
    end

    assign ram_addr  = (r_state == ST_MOD) ? r_item_col : r_dst_col;
    assign ram_we    = (r_state == ST_MOD);
    assign ram_wdata = n_entry;

    irds_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_DST_WIDTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Read-modify-write of the column entry. The first pixel of a region ignores
    // whatever an earlier region left behind.
    always_comb begin
        old_e    = r_item_fresh ? '0 : ram_rdata;
        luma_sum = 24'(r_px_r) * 24'(LUMA_K_R) + 24'(r_px_g) * 24'(LUMA_K_G)
                 + 24'(r_px_b) * 24'(LUMA_K_B);
        luma     = LUMA_W'(luma_sum[23:15]);
        pix      = {r_px_a, r_px_b, r_px_g, r_px_r};
        n_entry  = old_e;
        n_entry.sum_red   = old_e.sum_red   + SUM_W'(r_px_r);
        n_entry.sum_green = old_e.sum_green + SUM_W'(r_px_g);
        n_entry.sum_blue  = old_e.sum_blue  + SUM_W'(r_px_b);
        n_entry.sum_alpha = old_e.sum_alpha + SUM_W'(r_px_a);
        n_entry.pixel_count = old_e.pixel_count + 1'b1;
        if (r_mode == MODE_MAX) begin
            if (luma > old_e.best_luma) begin
                n_entry.best_luma  = luma;
                n_entry.best_pixel = pix;
            end
        end else if (r_mode == MODE_MIN) begin
            if (old_e.pixel_count == '0 || luma < old_e.best_luma) begin
                n_entry.best_luma  = luma;
                n_entry.best_pixel = pix;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_MOD;
            ST_MOD: begin
                if (!r_item_emit) begin
                    n_state = ST_IDLE;
                end else if (r_mode == MODE_AVG) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV:  if (r_div_cnt == 5'(DIV_STEPS - 1)) n_state = ST_OUT;
            ST_OUT:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Restoring divider, one quotient bit per cycle for all four channels.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rem_sh[k] = {r_rem[k][CNT_W-1:0], r_dvd[k][SUM_W-1]};
            trial[k]  = rem_sh[k] - {1'b0, r_divisor};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MOD) begin
            r_dvd[0]  <= n_entry.sum_red;
            r_dvd[1]  <= n_entry.sum_green;
            r_dvd[2]  <= n_entry.sum_blue;
            r_dvd[3]  <= n_entry.sum_alpha;
            for (int k = 0; k < 4; k++) r_rem[k] <= '0;
            r_divisor <= n_entry.pixel_count;
            r_div_cnt <= '0;
            r_res_pix <= (r_mode == MODE_MAX || r_mode == MODE_MIN)
                       ? n_entry.best_pixel : 32'd0;
        end else if (r_state == ST_DIV) begin
            for (int k = 0; k < 4; k++) begin
                if (!trial[k][CNT_W]) begin
                    r_rem[k] <= trial[k];
                    r_dvd[k] <= {r_dvd[k][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= rem_sh[k];
                    r_dvd[k] <= {r_dvd[k][SUM_W-2:0], 1'b0};
                end
            end
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // Alpha is already zero in the entry unless four channels are in use.
    assign out_pix = (r_mode == MODE_AVG)
                   ? {r_dvd[3][7:0], r_dvd[2][7:0], r_dvd[1][7:0], r_dvd[0][7:0]}
                   : r_res_pix;
    assign out_load = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {2'b00, r_item_col, r_item_row, out_pix};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef SYNTH
    a_accept_to_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_MOD)
        else $error("accepted beat did not move to the modify cycle");

    a_col_invariant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !r_init) |-> r_col_a <= r_col_b)
        else $error("source column ran past its region");

    a_row_invariant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !r_init) |-> r_row_a <= r_row_b)
        else $error("source row ran past its region");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_divisor != '0)
        else $error("divide by a zero pixel count");
`endif

endmodule

### verif/image_region_downscaler_unit_tb.sv
module image_region_downscaler_unit_tb
    import irds_pkg::*;
;

    // Mode code that the block leaves unused; it must give all-zero pixels.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Cycles to let pass before a register write, so that a region that is
    // still in the divider has surely left the block.
    localparam int DRAIN_CYCLES  = 48;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PIXELS = 380;

    // One reduced pixel as it leaves the block.
    typedef struct packed {
        logic [9:0]  col;
        logic [11:0] row;
        logic [7:0]  alpha;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_region_pixel;

    // The scoreboard keeps its own copy of the configuration and of the
    // per-column accumulators, and predicts the reduced pixel of each region.
    class downscale_scoreboard;
        logic [12:0] src_w_reg, src_h_reg, dst_h_reg;
        logic [10:0] dst_w_reg;
        logic [1:0]  mode_reg;
        logic [2:0]  chan_reg;
        int unsigned acc_r[MAX_DST_WIDTH], acc_g[MAX_DST_WIDTH];
        int unsigned acc_b[MAX_DST_WIDTH], acc_a[MAX_DST_WIDTH];
        int unsigned pick_luma[MAX_DST_WIDTH], pick_pix[MAX_DST_WIDTH];
        int unsigned npix[MAX_DST_WIDTH];
        int unsigned row_pos, col_pos, dst_row, dst_col, row_end, col_end;
        t_region_pixel expected_pixels[$];
        bit failed;

        function new();
            src_w_reg = 1; src_h_reg = 1; dst_w_reg = 1; dst_h_reg = 1;
            mode_reg = MODE_AVG; chan_reg = 3;
            failed = 0;
            restart_frame();
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function int unsigned eff_sw();
            return clamp(src_w_reg, 1, MAX_SRC_DIM);
        endfunction
        function int unsigned eff_sh();
            return clamp(src_h_reg, 1, MAX_SRC_DIM);
        endfunction
        function int unsigned eff_dw();
            int unsigned top;
            top = (eff_sw() < MAX_DST_WIDTH) ? eff_sw() : MAX_DST_WIDTH;
            return clamp(dst_w_reg, 1, top);
        endfunction
        function int unsigned eff_dh();
            return clamp(dst_h_reg, 1, eff_sh());
        endfunction

        // Exclusive source end of destination region idx.
        function int unsigned boundary(int unsigned idx, int unsigned src, int unsigned dst);
            longint unsigned prod;
            prod = longint'(idx + 1) * src;
            return int'(prod / dst);
        endfunction

        function void clear_column(int unsigned c);
            acc_r[c] = 0; acc_g[c] = 0; acc_b[c] = 0; acc_a[c] = 0;
            pick_luma[c] = 0; pick_pix[c] = 0; npix[c] = 0;
        endfunction

        function void restart_frame();
            for (int c = 0; c < MAX_DST_WIDTH; c++) clear_column(c);
            row_pos = 0; col_pos = 0; dst_row = 0; dst_col = 0;
            row_end = boundary(0, eff_sh(), eff_dh());
            col_end = boundary(0, eff_sw(), eff_dw());
        endfunction

        function void write_reg(logic [2:0] idx, logic [12:0] value);
            case (idx)
                REG_SRC_WIDTH:  src_w_reg = value;
                REG_SRC_HEIGHT: src_h_reg = value;
                REG_DST_WIDTH:  dst_w_reg = value[10:0];
                REG_DST_HEIGHT: dst_h_reg = value;
                REG_MODE:       mode_reg  = value[1:0];
                REG_CHANNELS:   chan_reg  = value[2:0];
                default: return;
            endcase
            restart_frame();
        endfunction

        function int outstanding();
            return expected_pixels.size();
        endfunction

        // Folds one accepted source pixel into its column and, where it
        // closes a region, queues the reduced pixel.
        function void note_pixel(logic [31:0] beat);
            int unsigned sw, sh, dw, dh, r, g, b, a, c, luma, pix, cnt;
            bit four;
            t_region_pixel res;
            sw = eff_sw(); sh = eff_sh(); dw = eff_dw(); dh = eff_dh();
            four = (chan_reg == 3'd4);
            r = beat[7:0]; g = beat[15:8]; b = beat[23:16];
            a = four ? beat[31:24] : 0;
            c = dst_col % MAX_DST_WIDTH;
            luma = (6969 * r + 23434 * g + 2365 * b) >> 15;
            pix = r | (g << 8) | (b << 16) | (a << 24);

            acc_r[c] += r; acc_g[c] += g; acc_b[c] += b; acc_a[c] += a;
            if (mode_reg == MODE_MAX) begin
                if (luma > pick_luma[c]) begin
                    pick_luma[c] = luma; pick_pix[c] = pix;
                end
            end else if (mode_reg == MODE_MIN) begin
                if (npix[c] == 0 || luma < pick_luma[c]) begin
                    pick_luma[c] = luma; pick_pix[c] = pix;
                end
            end
            npix[c]++;

            if (col_pos + 1 == col_end && row_pos + 1 == row_end) begin
                cnt = npix[c];
                res = '0;
                if (mode_reg == MODE_AVG) begin
                    res.red   = acc_r[c] / cnt;
                    res.green = acc_g[c] / cnt;
                    res.blue  = acc_b[c] / cnt;
                    res.alpha = four ? acc_a[c] / cnt : 0;
                end else if (mode_reg == MODE_MAX || mode_reg == MODE_MIN) begin
                    res.red   = pick_pix[c][7:0];
                    res.green = pick_pix[c][15:8];
                    res.blue  = pick_pix[c][23:16];
                    res.alpha = four ? pick_pix[c][31:24] : 0;
                end
                res.row = dst_row;
                res.col = dst_col;
                expected_pixels.push_back(res);
                clear_column(c);
            end

            col_pos++;
            if (col_pos >= sw) begin
                col_pos = 0;
                dst_col = 0;
                col_end = boundary(0, sw, dw);
                row_pos++;
                if (row_pos >= sh) begin
                    row_pos = 0;
                    dst_row = 0;
                    row_end = boundary(0, sh, dh);
                end else if (row_pos >= row_end) begin
                    dst_row++;
                    row_end = boundary(dst_row, sh, dh);
                end
            end else if (col_pos >= col_end) begin
                dst_col++;
                col_end = boundary(dst_col, sw, dw);
            end
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            failed = 1;
        endfunction

        function void check_result(logic [55:0] beat);
            t_region_pixel want, got;
            got = beat[53:0];
            if (expected_pixels.size() == 0) begin
                $display("%0t: result expected none actual %h", $time, beat);
                failed = 1;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red   !== want.red)   report("red",   want.red,   got.red);
            if (got.green !== want.green) report("green", want.green, got.green);
            if (got.blue  !== want.blue)  report("blue",  want.blue,  got.blue);
            if (got.alpha !== want.alpha) report("alpha", want.alpha, got.alpha);
            if (got.row   !== want.row)   report("row",   want.row,   got.row);
            if (got.col   !== want.col)   report("col",   want.col,   got.col);
            if (beat[55:54] !== 2'b00)    report("pad",   0,          beat[55:54]);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [12:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // in_red, in_green, in_blue, in_alpha
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // out_red, out_green, out_blue, out_alpha,
                                 // out_row, out_col, 2 zero bits

    downscale_scoreboard region_sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    image_region_downscaler_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The receiver samples the result beat at each edge and then decides,
    // with the current idling rate, whether to take the next one.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            region_sb.check_result(m_axis_tdata);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: counts edges at which no beat moves on either side and no
    // register is written. A hung block ends the run here.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("image_region_downscaler_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one source pixel, after an idle gap drawn from the sender's
    // idling rate, and holds it until the block takes it. tvalid stays high
    // afterwards so that back-to-back pixels see no bubble.
    task automatic send_pixel(input logic [31:0] pixel);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel;
        do @(posedge i_clk); while (!s_axis_tready);
        region_sb.note_pixel(pixel);
    endtask

    // Drops tvalid and waits until every expected reduced pixel has left
    // the block, then lets the divider latency pass as well.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (region_sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only happen once the block is drained.
    task automatic write_reg(input logic [2:0] idx, input logic [12:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        region_sb.write_reg(idx, value);
    endtask

    task automatic set_geometry(input int sw, input int sh, input int dw, input int dh,
                                input logic [1:0] mode, input int chans);
        drain_block();
        write_reg(REG_SRC_WIDTH,  13'(sw));
        write_reg(REG_SRC_HEIGHT, 13'(sh));
        write_reg(REG_DST_WIDTH,  13'(dw));
        write_reg(REG_DST_HEIGHT, 13'(dh));
        write_reg(REG_MODE,       13'(mode));
        write_reg(REG_CHANNELS,   13'(chans));
    endtask

    // Random pixel; now and then a dark one, whose channels and luminance are at most 3,
    // so that dark regions and luminance ties turn up in max and min modes.
    function automatic logic [31:0] random_pixel();
        logic [31:0] p;
        p = $urandom;
        if ($urandom_range(3) == 0) p[23:0] = {6'd0, p[17:16], 6'd0, p[9:8], 6'd0, p[1:0]};
        return p;
    endfunction

    initial begin
        int sw, sh, dw, dh, frame, sent, chans;
        logic [1:0] mode;
        bit paused;

        region_sb     = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_SRC_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        send_idle_pct = 18;
        recv_idle_pct = 88;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With the reset geometry every pixel is its own
        // region, so each extreme value comes straight back with its alpha zeroed.
        send_pixel(32'h0000_0000);
        send_pixel(32'hffff_ffff);
        send_pixel(32'h55aa_55aa);

        // Four channels, max mode: a dark 2x2 region (luminances no higher than 2)
        // and then one with a tie on the greatest luminance.
        set_geometry(2, 2, 1, 1, MODE_MAX, 4);
        send_pixel(32'h8001_0203);
        send_pixel(32'h0003_0000);
        send_pixel(32'h0000_0100);
        send_pixel(32'hff00_0001);
        send_pixel(32'h1100_8000);
        send_pixel(32'h2200_8000);
        send_pixel(32'h3300_4000);
        send_pixel(32'h4400_8000);

        // Min mode with a tie on the least luminance.
        set_geometry(2, 2, 1, 1, MODE_MIN, 4);
        send_pixel(32'h11ff_ffff);
        send_pixel(32'h2210_1010);
        send_pixel(32'h3310_1010);
        send_pixel(32'h4420_2020);

        // Unused mode and a channel count of zero, which means three.
        set_geometry(2, 1, 1, 1, MODE_UNUSED, 0);
        send_pixel(32'hffff_ffff);
        send_pixel(32'h1234_5678);

        // Out-of-range sizes: the source width clamps to the maximum, the
        // destination width to 1024 and the height to the source height.
        set_geometry(8191, 1, 8191, 8191, MODE_AVG, 7);
        repeat (8) send_pixel(random_pixel());

        // Tallest source with every row its own region; zero sizes clamp to one.
        set_geometry(2, 4096, 2, 4096, MODE_AVG, 4);
        repeat (4) send_pixel(random_pixel());
        set_geometry(0, 0, 0, 0, MODE_MAX, 3);
        send_pixel(32'hffff_ffff);

        // Random part: small frames with random geometry, mostly whole frames
        // and sometimes a frame cut short by the next register write or two frames in a row.
        sent = 0;
        paused = 0;
        while (sent < RANDOM_PIXELS) begin
            if (sent < RANDOM_PIXELS / 3) begin
                send_idle_pct = 18; recv_idle_pct = 88;
            end else if (sent < 2 * RANDOM_PIXELS / 3) begin
                send_idle_pct = 88; recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            sw = $urandom_range(1, 9);
            sh = $urandom_range(1, 6);
            dw = $urandom_range(1, sw);
            dh = $urandom_range(1, sh);
            if ($urandom_range(7) == 0) dw = $urandom_range(0, 12);
            if ($urandom_range(7) == 0) dh = $urandom_range(0, 8);
            mode  = 2'($urandom_range(3));
            chans = ($urandom_range(5) == 0) ? $urandom_range(7) : $urandom_range(3, 4);
            set_geometry(sw, sh, dw, dh, mode, chans);
            frame = sw * sh;
            if ($urandom_range(3) == 0) frame = $urandom_range(1, frame);
            else if ($urandom_range(3) == 0) frame = 2 * frame;
            for (int i = 0; i < frame; i++) begin
                send_pixel(random_pixel());
                sent++;
                // Once, the sender holds off until the block has caught up.
                if (!paused && sent >= RANDOM_PIXELS / 2) begin
                    paused = 1;
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (region_sb.outstanding() != 0) @(posedge i_clk);
                end
            end
        end

        // A wide single-row image: 4096 source columns into 1024 regions.
        set_geometry(4096, 1, 1024, 1, MODE_MIN, 4);
        repeat (40) send_pixel(random_pixel());

        drain_block();
        if (!region_sb.failed && region_sb.outstanding() == 0) begin
            $display("image_region_downscaler_unit: match");
        end else begin
            $display("image_region_downscaler_unit: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
design/irds_pkg.sv
design/irds_ram.sv
design/image_region_downscaler_unit.sv
verif/image_region_downscaler_unit_tb.sv
